[rtl/core/macd_pkg.sv]
// Shared types, constants and codes for the MACD crossover order generator.
package macd_pkg;

  localparam int PRICE_WIDTH      = 32;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int CLOSE_W  = 32;
  localparam int TIME_W   = 48;
  localparam int ID_W     = 32;
  localparam int QTY_W    = 32;
  localparam int PERIOD_W = 8;
  localparam int BARS_W   = 9;
  localparam int CFG_W    = 32;

  localparam logic [BARS_W-1:0]   BARS_MAX          = '1;
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = 8'd12;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 8'd26;
  localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = 8'd9;
  localparam logic [QTY_W-1:0]    ORDER_QTY_RST     = 32'd100;
  localparam logic [ID_W-1:0]     ORDER_ID_RST      = 32'd1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [1:0] {
    CFG_FAST_PERIOD   = 2'd0,
    CFG_SLOW_PERIOD   = 2'd1,
    CFG_SIGNAL_PERIOD = 2'd2,
    CFG_ORDER_QTY     = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_WB,
    ST_MACD,
    ST_CROSS,
    ST_EMIT
  } macd_state_t;

  typedef enum logic [1:0] {
    OP_FAST,
    OP_SLOW,
    OP_SIGNAL
  } ema_op_t;

  typedef struct packed {
    logic diff_en;
    logic mul_en;
    logic add_en;
  } ema_ctrl_t;

  typedef struct packed {
    logic [CLOSE_W-1:0] close_price;
    logic [TIME_W-1:0]  bar_time;
  } bar_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    order_id;
    logic               order_side;
    logic [CLOSE_W-1:0] order_price;
    logic [QTY_W-1:0]   order_size;
    logic [TIME_W-1:0]  order_time;
  } order_item_t;

endpackage

[rtl/core/macd_crossover_signal.sv]
// MACD crossover order generator: a new bar is taken only while the sequencer is idle.
// Three EMA updates (fast, slow, signal) run in turn through one shared difference/multiply/add unit,
// each as difference, multiply, add and write-back steps; MACD is formed before the signal update,
// then the crossing is tested. An order is registered from the emit state; a held output delays it.
// Synchronous active-low reset restores the configuration defaults, clears averages and counters,
// and sets the next order id to one.
module macd_crossover_signal #(
  parameter int PRICE_WIDTH      = macd_pkg::PRICE_WIDTH,
  parameter int WEIGHT_FRAC_BITS = macd_pkg::WEIGHT_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  macd_pkg::bar_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output macd_pkg::order_item_t        out_data,
  input  logic                         cfg_we,
  input  macd_pkg::cfg_index_t         cfg_index,
  input  logic [macd_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int PW = PRICE_WIDTH;
  localparam int VW = PRICE_WIDTH + 2;
  localparam int CW = macd_pkg::CLOSE_W;
  localparam logic [WEIGHT_FRAC_BITS:0] W_ONE = (WEIGHT_FRAC_BITS + 1)'(1) << WEIGHT_FRAC_BITS;

  // configuration
  logic [macd_pkg::PERIOD_W-1:0] fast_len_r;
  logic [macd_pkg::PERIOD_W-1:0] slow_len_r;
  logic [macd_pkg::PERIOD_W-1:0] sig_len_r;
  logic [macd_pkg::QTY_W-1:0]    order_qty_r;

  // strategy state
  logic [PW-1:0]                  fast_r;
  logic [PW-1:0]                  slow_r;
  logic signed [PW:0]             signal_r;
  logic signed [PW:0]             macd_r;
  logic signed [PW+1:0]           prev_diff_r;
  logic [macd_pkg::BARS_W-1:0]    bars_r;
  logic                           pos_r;
  logic [macd_pkg::ID_W-1:0]      next_id_r;

  // current transaction
  logic [PW-1:0]                  close_r;
  logic [macd_pkg::TIME_W-1:0]    time_r;
  logic                           first_r;
  logic [WEIGHT_FRAC_BITS:0]      w_r;

  macd_pkg::macd_state_t          state_r, state_nxt;
  macd_pkg::ema_op_t              op_r, op_nxt;
  macd_pkg::ema_ctrl_t            ctrl;

  logic                           out_valid_r;
  macd_pkg::order_item_t          out_data_r;

  logic [PW+CW-1:0]               close_in_ext;
  logic [PW+CW-1:0]               close_out_ext;
  logic [macd_pkg::PERIOD_W-1:0]  period_sel;
  logic [WEIGHT_FRAC_BITS:0]      rom_w;
  logic signed [VW-1:0]           op_prev;
  logic signed [VW-1:0]           op_x;
  logic signed [VW-1:0]           ema_res;
  logic signed [PW+1:0]           diff_now;
  logic [macd_pkg::BARS_W-1:0]    bars_nxt;
  logic [macd_pkg::BARS_W-1:0]    warm_len;
  logic                           up_cross;
  logic                           down_cross;
  logic                           emit;
  logic                           in_take;
  logic                           out_free;
  logic                           out_load;

  macd_weight_rom #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_weight_rom (
    .period(period_sel),
    .weight(rom_w)
  );

  macd_ema_unit #(
    .PRICE_WIDTH     (PRICE_WIDTH),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_ema_unit (
    .clk   (clk),
    .ctrl  (ctrl),
    .prev  (op_prev),
    .x     (op_x),
    .weight(w_r),
    .result(ema_res)
  );

  assign close_in_ext  = {{CW{1'b0}}, in_data.close_price};
  assign close_out_ext = {{CW{1'b0}}, close_r};

  // operand selection for the shared unit
  always_comb begin
    unique case (op_r)
      macd_pkg::OP_FAST: begin
        period_sel = fast_len_r;
        op_prev    = {2'b00, fast_r};
        op_x       = {2'b00, close_r};
      end
      macd_pkg::OP_SLOW: begin
        period_sel = slow_len_r;
        op_prev    = {2'b00, slow_r};
        op_x       = {2'b00, close_r};
      end
      macd_pkg::OP_SIGNAL: begin
        period_sel = sig_len_r;
        op_prev    = {signal_r[PW], signal_r};
        op_x       = {macd_r[PW], macd_r};
      end
      default: begin
        period_sel = sig_len_r;
        op_prev    = {signal_r[PW], signal_r};
        op_x       = {macd_r[PW], macd_r};
      end
    endcase
  end

  // crossing test
  always_comb begin
    diff_now   = {macd_r[PW], macd_r} - {signal_r[PW], signal_r};
    bars_nxt   = (bars_r == macd_pkg::BARS_MAX) ? bars_r : bars_r + macd_pkg::BARS_W'(1);
    warm_len   = macd_pkg::BARS_W'(slow_len_r) + macd_pkg::BARS_W'(sig_len_r);
    up_cross   = (prev_diff_r <= 0) && (diff_now > 0);
    down_cross = (prev_diff_r >= 0) && (diff_now < 0);
    emit       = (bars_nxt >= warm_len) && ((up_cross && !pos_r) || (down_cross && pos_r));
  end

  assign in_stall = (state_r != macd_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == macd_pkg::ST_EMIT) && out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ctrl      = '0;
    unique case (state_r)
      macd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = macd_pkg::ST_DIFF;
          op_nxt    = macd_pkg::OP_FAST;
        end
      end
      macd_pkg::ST_DIFF: begin
        ctrl.diff_en = 1'b1;
        state_nxt    = macd_pkg::ST_MUL;
      end
      macd_pkg::ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = macd_pkg::ST_ADD;
      end
      macd_pkg::ST_ADD: begin
        ctrl.add_en = 1'b1;
        state_nxt   = macd_pkg::ST_WB;
      end
      macd_pkg::ST_WB: begin
        unique case (op_r)
          macd_pkg::OP_FAST: begin
            state_nxt = macd_pkg::ST_DIFF;
            op_nxt    = macd_pkg::OP_SLOW;
          end
          macd_pkg::OP_SLOW:   state_nxt = macd_pkg::ST_MACD;
          default:             state_nxt = macd_pkg::ST_CROSS;
        endcase
      end
      macd_pkg::ST_MACD: begin
        state_nxt = macd_pkg::ST_DIFF;
        op_nxt    = macd_pkg::OP_SIGNAL;
      end
      macd_pkg::ST_CROSS: begin
        state_nxt = emit ? macd_pkg::ST_EMIT : macd_pkg::ST_IDLE;
      end
      macd_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = macd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = macd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= macd_pkg::ST_IDLE;
      op_r    <= macd_pkg::OP_FAST;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_len_r  <= macd_pkg::FAST_PERIOD_RST;
      slow_len_r  <= macd_pkg::SLOW_PERIOD_RST;
      sig_len_r   <= macd_pkg::SIGNAL_PERIOD_RST;
      order_qty_r <= macd_pkg::ORDER_QTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        macd_pkg::CFG_FAST_PERIOD:   fast_len_r  <= cfg_wdata[macd_pkg::PERIOD_W-1:0];
        macd_pkg::CFG_SLOW_PERIOD:   slow_len_r  <= cfg_wdata[macd_pkg::PERIOD_W-1:0];
        macd_pkg::CFG_SIGNAL_PERIOD: sig_len_r   <= cfg_wdata[macd_pkg::PERIOD_W-1:0];
        macd_pkg::CFG_ORDER_QTY:     order_qty_r <= cfg_wdata[macd_pkg::QTY_W-1:0];
      endcase
    end
  end

  // strategy state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r      <= '0;
      slow_r      <= '0;
      signal_r    <= '0;
      prev_diff_r <= '0;
      bars_r      <= '0;
      pos_r       <= 1'b0;
      next_id_r   <= macd_pkg::ORDER_ID_RST;
    end else begin
      if (state_r == macd_pkg::ST_WB) begin
        unique case (op_r)
          macd_pkg::OP_FAST:   fast_r   <= ema_res[PW-1:0];
          macd_pkg::OP_SLOW:   slow_r   <= ema_res[PW-1:0];
          macd_pkg::OP_SIGNAL: signal_r <= ema_res[PW:0];
          default:             signal_r <= ema_res[PW:0];
        endcase
      end
      if (state_r == macd_pkg::ST_CROSS) begin
        prev_diff_r <= diff_now;
        bars_r      <= bars_nxt;
      end
      if (out_load) begin
        pos_r     <= !pos_r;
        next_id_r <= next_id_r + macd_pkg::ID_W'(1);
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      close_r <= close_in_ext[PW-1:0];
      time_r  <= in_data.bar_time;
      first_r <= (bars_r == '0);
    end
    if (state_r == macd_pkg::ST_DIFF) begin
      // a weight of one seeds the average with its input on the first bar
      w_r <= first_r ? W_ONE : rom_w;
    end
    if (state_r == macd_pkg::ST_MACD) begin
      macd_r <= $signed({1'b0, fast_r}) - $signed({1'b0, slow_r});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.order_id    <= next_id_r;
      out_data_r.order_side  <= pos_r ? macd_pkg::SIDE_SELL : macd_pkg::SIDE_BUY;
      out_data_r.order_price <= close_out_ext[CW-1:0];
      out_data_r.order_size  <= order_qty_r;
      out_data_r.order_time  <= time_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_after_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == macd_pkg::ST_EMIT) |-> (bars_r >= warm_len))
    else $error("order pending before warmup complete");

  a_id_advances: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (next_id_r == $past(next_id_r) + macd_pkg::ID_W'(1)))
    else $error("order id did not advance with an order");

  a_position_needs_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != $past(pos_r)) |-> $past(out_load))
    else $error("position changed without an order");

endmodule

[rtl/core/macd_weight_rom.sv]
// Constant table of EMA weights 2/(period+1) in Q1.F, indexed by period.
module macd_weight_rom #(
  parameter int WEIGHT_FRAC_BITS = macd_pkg::WEIGHT_FRAC_BITS
) (
  input  logic [macd_pkg::PERIOD_W-1:0] period,
  output logic [WEIGHT_FRAC_BITS:0]     weight
);

  localparam int DEPTH = 1 << macd_pkg::PERIOD_W;

  logic [WEIGHT_FRAC_BITS:0] tab [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    // period zero behaves as period one
    localparam longint unsigned P   = (i == 0) ? 1 : i;
    localparam longint unsigned NUM = 64'd1 << (WEIGHT_FRAC_BITS + 1);
    localparam longint unsigned W   = (NUM + (P + 1) / 2) / (P + 1);
    assign tab[i] = (WEIGHT_FRAC_BITS + 1)'(W);
  end

  assign weight = tab[period];

endmodule

[rtl/core/macd_ema_unit.sv]
// Shared EMA update unit: difference, weight multiply, rounded step add.
module macd_ema_unit #(
  parameter int PRICE_WIDTH      = macd_pkg::PRICE_WIDTH,
  parameter int WEIGHT_FRAC_BITS = macd_pkg::WEIGHT_FRAC_BITS
) (
  input  logic                        clk,
  input  macd_pkg::ema_ctrl_t         ctrl,
  input  logic signed [PRICE_WIDTH+1:0] prev,
  input  logic signed [PRICE_WIDTH+1:0] x,
  input  logic [WEIGHT_FRAC_BITS:0]   weight,
  output logic signed [PRICE_WIDTH+1:0] result
);

  localparam int VW     = PRICE_WIDTH + 2;
  localparam int MW     = PRICE_WIDTH + 1;
  localparam int PROD_W = MW + WEIGHT_FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (WEIGHT_FRAC_BITS - 1);

  logic signed [VW-1:0]  diff;
  logic [VW-1:0]         diff_abs;
  logic                  neg_r;
  logic [MW-1:0]         mag_r;
  logic signed [VW-1:0]  prev_r;
  logic [PROD_W-1:0]     prod_c;
  logic [PROD_W-1:0]     prod_r;
  logic [SUM_W-1:0]      rounded;
  logic [SUM_W-1:0]      step_wide;
  logic signed [VW-1:0]  step;
  logic signed [VW-1:0]  res_r;

  always_comb begin
    diff     = x - prev;
    diff_abs = diff[VW-1] ? VW'(-diff) : VW'(diff);
    prod_c   = PROD_W'(mag_r) * PROD_W'(weight);
    // round half away from zero on the magnitude
    rounded   = SUM_W'(prod_r) + HALF;
    step_wide = rounded >> WEIGHT_FRAC_BITS;
    step      = $signed(step_wide[VW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      neg_r  <= diff[VW-1];
      mag_r  <= diff_abs[MW-1:0];
      prev_r <= prev;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_c;
    end
    if (ctrl.add_en) begin
      res_r <= neg_r ? (prev_r - step) : (prev_r + step);
    end
  end

  assign result = res_r;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the MACD crossover order generator.
`timescale 1ns / 100ps

module tb;
  import macd_pkg::*;

  localparam int     DRAIN_CYCLES   = 32;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam longint PRICE_TOP      = 64'h0000_0000_FFFF_FFFF;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  bar_item_t            in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  order_item_t          out_data;
  logic                 cfg_we    = 1'b0;
  cfg_index_t           cfg_index = CFG_FAST_PERIOD;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Mirror of the block's configuration and running state
  logic [PERIOD_W-1:0]  fast_len      = FAST_PERIOD_RST;
  logic [PERIOD_W-1:0]  slow_len      = SLOW_PERIOD_RST;
  logic [PERIOD_W-1:0]  sig_len       = SIGNAL_PERIOD_RST;
  logic [QTY_W-1:0]     order_qty     = ORDER_QTY_RST;
  logic [31:0]          fast_avg      = '0;
  logic [31:0]          slow_avg      = '0;
  logic signed [32:0]   sig_avg       = '0;
  logic [BARS_W-1:0]    bar_count     = '0;
  logic signed [33:0]   prev_diff     = '0;
  logic                 holding       = 1'b0;
  logic [ID_W-1:0]      next_order_id = ORDER_ID_RST;

  order_item_t          pending_orders[$];
  order_item_t          expected_order;
  int                   mismatches       = 0;
  int                   stall_pct        = 0;
  int                   stall_left       = 0;
  int                   quiet_cycles     = 0;

  macd_crossover_signal uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // One EMA update: weight 2/(period+1) in Q1.16, step rounded half away from zero
  function automatic longint ema_next(input longint prev, input longint x,
                                      input logic [PERIOD_W-1:0] period);
    longint unsigned p;
    longint unsigned w;
    longint unsigned mag;
    longint unsigned step_v;
    longint          d;
    p = (period == 0) ? 64'd1 : {56'd0, period};
    w = ((64'd1 << (WEIGHT_FRAC_BITS + 1)) + (p + 1) / 2) / (p + 1);
    d = x - prev;
    mag = (d < 0) ? -d : d;
    step_v = (mag * w + (64'd1 << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
    return (d < 0) ? prev - signed'(step_v) : prev + signed'(step_v);
  endfunction

  // Advance the averages by one bar; returns 1 when the bar places an order
  function automatic bit advance_macd(input bar_item_t bar, output order_item_t order);
    longint close_v;
    longint fast_v;
    longint slow_v;
    longint macd_v;
    longint sig_v;
    longint diff_v;
    longint prev_v;
    bit     rising;
    bit     falling;
    order = '0;
    close_v = {32'd0, bar.close_price};
    if (bar_count == 0) begin
      fast_v = close_v;
      slow_v = close_v;
    end else begin
      fast_v = ema_next({32'd0, fast_avg}, close_v, fast_len);
      slow_v = ema_next({32'd0, slow_avg}, close_v, slow_len);
    end
    macd_v = fast_v - slow_v;
    sig_v = (bar_count == 0) ? macd_v : ema_next(longint'(sig_avg), macd_v, sig_len);
    fast_avg = fast_v[31:0];
    slow_avg = slow_v[31:0];
    sig_avg = sig_v[32:0];
    if (bar_count != BARS_MAX) bar_count++;
    diff_v = macd_v - sig_v;
    prev_v = longint'(prev_diff);
    prev_diff = diff_v[33:0];
    // still warming up: only the difference is tracked
    if (int'(bar_count) < int'(slow_len) + int'(sig_len)) return 1'b0;
    rising = (prev_v <= 0) && (diff_v > 0);
    falling = (prev_v >= 0) && (diff_v < 0);
    if (rising && !holding) begin
      order.order_side = SIDE_BUY;
      holding = 1'b1;
    end else if (falling && holding) begin
      order.order_side = SIDE_SELL;
      holding = 1'b0;
    end else begin
      return 1'b0;
    end
    order.order_id = next_order_id;
    order.order_price = bar.close_price;
    order.order_size = order_qty;
    order.order_time = bar.bar_time;
    next_order_id++;
    return 1'b1;
  endfunction

  // Period register word with random upper bits, which the block must ignore
  function automatic logic [CFG_W-1:0] period_word(input logic [PERIOD_W-1:0] p);
    logic [31:0] r;
    r = $urandom;
    return {r[31:8], p};
  endfunction

  task automatic send_bar(input logic [CLOSE_W-1:0] close_v, input logic [TIME_W-1:0] time_v);
    bar_item_t   bar;
    order_item_t order;
    bar.close_price = close_v;
    bar.bar_time = time_v;
    in_valid <= 1'b1;
    in_data <= bar;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_macd(bar, order)) begin
      pending_orders = {pending_orders, order};
    end
  endtask

  task automatic hold_off(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid, wait for every order, then let a bar with no order finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] fast_w, input logic [CFG_W-1:0] slow_w,
                             input logic [CFG_W-1:0] signal_w, input logic [CFG_W-1:0] qty_w);
    put_reg(CFG_FAST_PERIOD, fast_w);
    put_reg(CFG_SLOW_PERIOD, slow_w);
    put_reg(CFG_SIGNAL_PERIOD, signal_w);
    put_reg(CFG_ORDER_QTY, qty_w);
    cfg_we <= 1'b0;
    fast_len = fast_w[PERIOD_W-1:0];
    slow_len = slow_w[PERIOD_W-1:0];
    sig_len = signal_w[PERIOD_W-1:0];
    order_qty = qty_w;
  endtask

  // First bar and field extremes under the reset configuration (all inside warmup)
  task automatic test_extreme_bars();
    stall_pct = 0;
    send_bar(32'h0000_0000, 48'h0000_0000_0000);
    send_bar(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_bar(32'h0000_0000, 48'h0000_0000_0001);
    send_bar(32'hFFFF_FFFF, 48'h8000_0000_0000);
    send_bar(32'h8000_0000, 48'h5555_5555_5555);
    send_bar(32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA);
    settle();
  endtask

  // Short periods, zero fast period, swinging prices: buys, sells and ignored crossings
  task automatic test_crossings();
    logic [CLOSE_W-1:0] swing[10];
    swing = '{32'h1000_0000, 32'hF000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h2000_0000,
              32'h3000_0000, 32'h4000_0000, 32'h1000_0000, 32'h0800_0000, 32'hC000_0000};
    stall_pct = 50;
    load_config(period_word(8'd0), period_word(8'd3), period_word(8'd2), 32'hFFFF_FFFF);
    foreach (swing[i]) begin
      send_bar(swing[i], 48'(i));
      if (i % 3 == 2) hold_off($urandom_range(1, 6));
    end
    settle();
  endtask

  // Flat MACD gives a zero difference; crossings then start from zero
  task automatic test_zero_difference();
    load_config(period_word(8'd1), period_word(8'd1), period_word(8'd1), 32'd7);
    repeat (3) send_bar(32'h1234_5678, 48'h0000_1234_5678);
    settle();
    load_config(period_word(8'd1), period_word(8'd3), period_word(8'd2), 32'd0);
    send_bar(32'h2000_0000, 48'h0000_0000_0010);
    send_bar(32'h0100_0000, 48'h0000_0000_0011);
    send_bar(32'h3000_0000, 48'h0000_0000_0012);
    send_bar(32'h0000_0100, 48'h0000_0000_0013);
    settle();
  endtask

  // Trending price segments with noise, across several configurations and idle patterns
  task automatic test_random_phases();
    int                 n_items;
    int                 k;
    int                 pick;
    int                 burst_left;
    int                 seg_left;
    bit                 gaps_on;
    longint             level;
    longint             slope;
    logic [63:0]        r;
    logic [CLOSE_W-1:0] close_v;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          load_config(period_word(8'd255), period_word(8'd255), period_word(8'd255), 32'd0);
          n_items = 250;
        end
        1: begin
          load_config(period_word(8'd1), period_word(8'd255), period_word(8'd255), '1);
          n_items = 250;
        end
        2: begin
          load_config(period_word(8'd12), period_word(8'd26), period_word(8'd9), $urandom);
          n_items = 200;
        end
        default: begin
          load_config(period_word(8'($urandom_range(0, 30))), period_word(8'($urandom_range(1, 60))),
                      period_word(8'($urandom_range(0, 30))), $urandom);
          n_items = 200;
        end
      endcase
      gaps_on = (ph % 2 == 1);
      stall_pct = (ph % 3) * 35;
      burst_left = $urandom_range(1, 16);
      seg_left = 0;
      slope = 0;
      level = longint'($urandom);
      k = 0;
      while (k < n_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          close_v = $urandom;
        end else if (pick < 10) begin
          close_v = pick[0] ? '1 : '0;
        end else begin
          if (seg_left == 0) begin
            seg_left = $urandom_range(3, 40);
            slope = longint'($urandom_range(0, 1 << $urandom_range(4, 24)));
            if ($urandom_range(0, 1)) slope = -slope;
          end
          seg_left--;
          level += slope + longint'($urandom_range(0, 4095)) - 2048;
          if (level < 0) begin
            level = 0;
            slope = -slope;
          end
          if (level > PRICE_TOP) begin
            level = PRICE_TOP;
            slope = -slope;
          end
          close_v = level[31:0];
        end
        r = {$urandom, $urandom};
        send_bar(close_v, r[TIME_W-1:0]);
        k++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          if (gaps_on) hold_off($urandom_range(1, 12));
        end
      end
      settle();
    end
  endtask

  // Receiver: stall in runs of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_left <= $urandom_range(1, 20);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Compare each delivered order with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_orders.size() == 0) begin
        $error("order_id: expected no order, got %0d", out_data.order_id);
        mismatches++;
      end else begin
        expected_order = pending_orders.pop_front();
        if (out_data.order_id !== expected_order.order_id) begin
          $error("order_id: expected %0d, got %0d", expected_order.order_id, out_data.order_id);
          mismatches++;
        end
        if (out_data.order_side !== expected_order.order_side) begin
          $error("order_side: expected %0d, got %0d", expected_order.order_side,
                 out_data.order_side);
          mismatches++;
        end
        if (out_data.order_price !== expected_order.order_price) begin
          $error("order_price: expected %0h, got %0h", expected_order.order_price,
                 out_data.order_price);
          mismatches++;
        end
        if (out_data.order_size !== expected_order.order_size) begin
          $error("order_size: expected %0h, got %0h", expected_order.order_size,
                 out_data.order_size);
          mismatches++;
        end
        if (out_data.order_time !== expected_order.order_time) begin
          $error("order_time: expected %0h, got %0h", expected_order.order_time,
                 out_data.order_time);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_bars();
    test_crossings();
    test_zero_difference();
    test_random_phases();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/macd_pkg.sv
rtl/core/macd_weight_rom.sv
rtl/core/macd_ema_unit.sv
rtl/core/macd_crossover_signal.sv
tb/sv/tb.sv
